[rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for concurrent assertions, clocked and reset-qualified.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define TKSS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("top-k selector check failed");

// next-cycle implication
`define TKSS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("top-k selector check failed");

`endif

[rtl/tkss_pkg.sv]
// ---------------------------------------------------------------------------
// tkss_pkg
// Constants, types and helpers shared by the top-k score selector.
// ---------------------------------------------------------------------------
package tkss_pkg;

   localparam int K_MAX       = 16;
   localparam int MAX_ITEMS   = 1024;
   localparam int TOP_COUNT_W = 5;
   localparam int SCORE_W     = 32;
   localparam int CLASS_IDX_W = 10;
   localparam int RANK_W      = 4;
   localparam int CNT_W       = $clog2(K_MAX + 1);
   localparam int POS_W       = (K_MAX > 1) ? $clog2(K_MAX) : 1;
   localparam int ITEM_W      = $clog2(MAX_ITEMS + 1);

   localparam logic [TOP_COUNT_W-1:0] TOP_COUNT_RESET = TOP_COUNT_W'(5);

   typedef struct packed {
      logic signed [SCORE_W-1:0] score;
      logic [CLASS_IDX_W-1:0]    index;
   } entry_type;

   typedef entry_type [K_MAX-1:0] list_type;

   // one finished stream: sorted list, fill count and k at capture
   typedef struct packed {
      list_type         list;
      logic [CNT_W-1:0] count;
      logic [CNT_W-1:0] k;
   } snap_type;

   typedef struct packed {
      logic [CLASS_IDX_W-1:0]    class_index;
      logic signed [SCORE_W-1:0] class_score;
      logic [RANK_W-1:0]         rank;
      logic                      entry_valid;
      logic                      last_result;
   } rsp_word_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   // clamp top_count to 1..K_MAX
   function automatic logic [CNT_W-1:0] eff_k(input logic [TOP_COUNT_W-1:0] tc);
      int t;
      t = int'(tc);
      if (t < 1) t = 1;
      if (t > K_MAX) t = K_MAX;
      return CNT_W'(t);
   endfunction

endpackage

[rtl/tkss_front.sv]
// ---------------------------------------------------------------------------
// tkss_front
// Compare-and-shift insertion list; hands a snapshot off on the last item.
// ---------------------------------------------------------------------------
module tkss_front import tkss_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      accept,
   input  logic signed [SCORE_W-1:0] score,
   input  logic                      last_item,
   input  logic [CNT_W-1:0]          k,
   output logic                      snap_push,
   output snap_type                  snap_data
);

   list_type          list_ff, list_in;
   logic [CNT_W-1:0]  filled_ff, filled_in;
   logic [ITEM_W-1:0] next_idx_ff, next_idx_in;

   logic [CNT_W-1:0]  fc, count_new;
   logic [K_MAX-1:0]  after, prev_after;
   list_type          prev_entry;
   entry_type         new_entry;
   logic              take, ins;

   always_comb begin
      fc        = (filled_ff > k) ? k : filled_ff;
      take      = next_idx_ff < ITEM_W'(MAX_ITEMS);
      new_entry = '{score: score, index: CLASS_IDX_W'(next_idx_ff)};

      // slot j is at or below the insertion point
      for (int j = 0; j < K_MAX; j++) begin
         after[j] = (CNT_W'(j) >= fc) || ($signed(list_ff[j].score) < score);
      end
      prev_after[0] = 1'b0;
      prev_entry[0] = list_ff[0];
      for (int j = 1; j < K_MAX; j++) begin
         prev_after[j] = after[j-1];
         prev_entry[j] = list_ff[j-1];
      end

      ins       = take && after[POS_W'(k - CNT_W'(1))];
      count_new = (ins && (fc < k)) ? fc + CNT_W'(1) : fc;

      list_in = list_ff;
      for (int j = 0; j < K_MAX; j++) begin
         if (ins && after[j] && (CNT_W'(j) < k)) begin
            list_in[j] = prev_after[j] ? prev_entry[j] : new_entry;
         end
      end

      filled_in   = filled_ff;
      next_idx_in = next_idx_ff;
      if (accept) begin
         filled_in   = last_item ? '0 : count_new;
         next_idx_in = last_item ? '0 : (take ? next_idx_ff + ITEM_W'(1) : next_idx_ff);
      end

      snap_push = accept && last_item;
      snap_data = '{list: list_in, count: count_new, k: k};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         filled_ff   <= '0;
         next_idx_ff <= '0;
      end else begin
         filled_ff   <= filled_in;
         next_idx_ff <= next_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         list_ff <= list_in;
      end
   end

endmodule

[rtl/tkss_snap_q.sv]
// ---------------------------------------------------------------------------
// tkss_snap_q
// Two-deep queue of finished lists between front and back.
// ---------------------------------------------------------------------------
module tkss_snap_q import tkss_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  snap_type     push_data,
   input  logic         pop,
   output snap_type     head,
   output q_status_type status
);

   snap_type   head_ff, head_in;
   snap_type   tail_ff, tail_in;
   logic [1:0] cnt_ff, cnt_in;

   always_comb begin
      head_in = head_ff;
      tail_in = tail_ff;
      cnt_in  = cnt_ff;
      case (cnt_ff)
         2'd0: begin
            if (push) begin
               head_in = push_data;
               cnt_in  = 2'd1;
            end
         end
         2'd1: begin
            if (push && pop) begin
               head_in = push_data;
            end else if (push) begin
               tail_in = push_data;
               cnt_in  = 2'd2;
            end else if (pop) begin
               cnt_in  = 2'd0;
            end
         end
         2'd2: begin
            if (pop) begin
               head_in = tail_ff;
               cnt_in  = 2'd1;
            end
         end
         default: begin
            cnt_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   assign head         = head_ff;
   assign status.full  = (cnt_ff == 2'd2);
   assign status.empty = (cnt_ff == 2'd0);

endmodule

[rtl/tkss_back.sv]
// ---------------------------------------------------------------------------
// tkss_back
// Walks a queued list best to worst and feeds a two-word result buffer.
// ---------------------------------------------------------------------------
module tkss_back import tkss_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  snap_type     head,
   input  logic         q_empty,
   output logic         q_pop,
   input  logic         rsp_pop,
   output logic         rsp_empty,
   output rsp_word_type rsp_word
);

   logic [POS_W-1:0] rank_ff, rank_in;
   rsp_word_type     out_ff, out_in;
   rsp_word_type     skid_ff, skid_in;
   logic [1:0]       cnt_ff, cnt_in;

   rsp_word_type     word;
   entry_type        sel;
   logic             gen, pop_ok, is_last, is_valid;

   always_comb begin
      sel      = head.list[rank_ff];
      is_valid = CNT_W'(rank_ff) < head.count;
      is_last  = CNT_W'(rank_ff) == (head.k - CNT_W'(1));
      word     = '{class_index: is_valid ? sel.index : '0,
                   class_score: is_valid ? sel.score : '0,
                   rank:        RANK_W'(rank_ff),
                   entry_valid: is_valid,
                   last_result: is_last};

      gen    = !q_empty && (cnt_ff != 2'd2);
      pop_ok = rsp_pop && (cnt_ff != 2'd0);
      q_pop  = gen && is_last;

      rank_in = rank_ff;
      if (gen) begin
         rank_in = is_last ? '0 : rank_ff + POS_W'(1);
      end
   end

   // result buffer: out word shown, skid word behind it
   always_comb begin
      out_in  = out_ff;
      skid_in = skid_ff;
      cnt_in  = cnt_ff;
      case (cnt_ff)
         2'd0: begin
            if (gen) begin
               out_in = word;
               cnt_in = 2'd1;
            end
         end
         2'd1: begin
            if (gen && pop_ok) begin
               out_in  = word;
            end else if (gen) begin
               skid_in = word;
               cnt_in  = 2'd2;
            end else if (pop_ok) begin
               cnt_in  = 2'd0;
            end
         end
         2'd2: begin
            if (pop_ok) begin
               out_in = skid_ff;
               cnt_in = 2'd1;
            end
         end
         default: begin
            cnt_in = 2'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rank_ff <= '0;
         cnt_ff  <= 2'd0;
      end else begin
         rank_ff <= rank_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_empty = (cnt_ff == 2'd0);
   assign rsp_word  = out_ff;

endmodule

[rtl/top_k_score_selector_core.sv]
// ---------------------------------------------------------------------------
// top_k_score_selector_core
// Streaming top-k selection over a vector of signed Q16.16 class scores.
// ---------------------------------------------------------------------------
// Scores enter one word per cycle while full is low, through push/full, and
// are numbered from 0 in arrival order; the front keeps the best top_count
// of them (clamped to 1..K_MAX) in a list sorted best to worst, updated by a
// parallel compare-and-shift insertion, so full stays low while the list work
// runs. Equal scores keep the earlier index ahead. Indices of MAX_ITEMS and
// above are not inserted. On the word marked last_item the finished list moves
// into a two-deep queue and the front starts the next vector on the very next
// cycle. The back reads the queue and emits k result words, ranked from 0, one
// per cycle while its result buffer has room; ranks with no received score
// show entry_valid low with zero index and score, and the last word of a
// vector has last_result set. full rises only when two finished vectors are
// still waiting for the back, e.g. when vectors shorter than k words arrive
// faster than results are drained. With the back idle, a vector's rank-0 word
// passes the queue and the back's out register before it shows on the result
// ports. top_count is written through csr_valid/csr_ready (always ready); the
// user must write it only while the block is idle; no logic enforces this.
// ---------------------------------------------------------------------------
module top_k_score_selector_core import tkss_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   // score input
   input  logic                          push,
   output logic                          full,
   input  logic signed [SCORE_W-1:0]     req_score,
   input  logic                          req_last_item,
   // ranked results
   output logic                          empty,
   input  logic                          pop,
   output logic [CLASS_IDX_W-1:0]        rsp_class_index,
   output logic signed [SCORE_W-1:0]     rsp_class_score,
   output logic [RANK_W-1:0]             rsp_rank,
   output logic                          rsp_entry_valid,
   output logic                          rsp_last_result,
   // top_count register
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [TOP_COUNT_W-1:0]        csr_top_count
);

   logic [TOP_COUNT_W-1:0] top_count_ff, top_count_in;
   logic [CNT_W-1:0]       k;
   logic                   accept;
   logic                   snap_push, snap_pop;
   snap_type               snap_data, snap_head;
   q_status_type           q_status;
   rsp_word_type           rsp_word;

   // register port never stalls
   assign csr_ready    = 1'b1;
   assign top_count_in = (csr_valid && csr_ready) ? csr_top_count : top_count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_count_ff <= TOP_COUNT_RESET;
      end else begin
         top_count_ff <= top_count_in;
      end
   end

   assign k      = eff_k(top_count_ff);
   assign full   = q_status.full;
   assign accept = push && !full;

   tkss_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .score     (req_score),
      .last_item (req_last_item),
      .k         (k),
      .snap_push (snap_push),
      .snap_data (snap_data)
   );

   tkss_snap_q u_snap_q (
      .clock     (clock),
      .reset     (reset),
      .push      (snap_push),
      .push_data (snap_data),
      .pop       (snap_pop),
      .head      (snap_head),
      .status    (q_status)
   );

   tkss_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (snap_head),
      .q_empty   (q_status.empty),
      .q_pop     (snap_pop),
      .rsp_pop   (pop),
      .rsp_empty (empty),
      .rsp_word  (rsp_word)
   );

   assign rsp_class_index = rsp_word.class_index;
   assign rsp_class_score = rsp_word.class_score;
   assign rsp_rank        = rsp_word.rank;
   assign rsp_entry_valid = rsp_word.entry_valid;
   assign rsp_last_result = rsp_word.last_result;

endmodule

[rtl/tkss_checker.sv]
// ---------------------------------------------------------------------------
// tkss_checker
// Port-level checks on the ranked result stream, bound to the core.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module tkss_checker import tkss_pkg::*; (
   input logic                      clock,
   input logic                      reset,
   input logic                      empty,
   input logic                      pop,
   input logic [CLASS_IDX_W-1:0]    rsp_class_index,
   input logic signed [SCORE_W-1:0] rsp_class_score,
   input logic [RANK_W-1:0]         rsp_rank,
   input logic                      rsp_entry_valid,
   input logic                      rsp_last_result
);

   // a new vector starts at rank 0
   `TKSS_ASSERT_NEXT(a_rank_restart, clock, reset, pop && !empty && rsp_last_result, empty || (rsp_rank == '0))

   // ranks step by one within a vector
   `TKSS_ASSERT_NEXT(a_rank_step, clock, reset, pop && !empty && !rsp_last_result, empty || (rsp_rank == RANK_W'($past(rsp_rank) + RANK_W'(1))))

   // once a rank is empty, the rest of the vector is empty too
   `TKSS_ASSERT_NEXT(a_valid_tail, clock, reset, pop && !empty && !rsp_entry_valid && !rsp_last_result, empty || !rsp_entry_valid)

   // empty ranks carry zero payload
   `TKSS_ASSERT_IMPL(a_invalid_zero, clock, reset, !empty && !rsp_entry_valid, (rsp_class_index == '0) && (rsp_class_score == '0))

   // a waiting word holds until taken
   `TKSS_ASSERT_NEXT(a_hold, clock, reset, !empty && !pop, !empty && $stable(rsp_class_score) && $stable(rsp_rank))

endmodule

bind top_k_score_selector_core tkss_checker u_tkss_checker (.*);

[verif/testbench.sv]
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for top_k_score_selector_core: streams score words
// through the push/full side, tracks the sorted best-k list on the side and
// checks every ranked word that pops out, field by field, in order.
// ---------------------------------------------------------------------------
module testbench import tkss_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   // cycles the block needs to go quiet after its last ranked word
   localparam int SETTLE   = 6;
   localparam int DIR_ROWS = 22;
   localparam int RAND_ITEMS = 440;

   // ------------------------------------------------------------------
   // DUT signals, the inputs all driven to known values from time zero
   // ------------------------------------------------------------------
   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       push = 1'b0;
   logic                       full;
   logic signed [SCORE_W-1:0]  req_score = '0;
   logic                       req_last_item = 1'b0;
   logic                       empty;
   logic                       pop = 1'b0;
   logic [CLASS_IDX_W-1:0]     rsp_class_index;
   logic signed [SCORE_W-1:0]  rsp_class_score;
   logic [RANK_W-1:0]          rsp_rank;
   logic                       rsp_entry_valid;
   logic                       rsp_last_result;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic [TOP_COUNT_W-1:0]     csr_top_count = '0;

   top_k_score_selector_core dut (
      .clock           (clock),
      .reset           (reset),
      .push            (push),
      .full            (full),
      .req_score       (req_score),
      .req_last_item   (req_last_item),
      .empty           (empty),
      .pop             (pop),
      .rsp_class_index (rsp_class_index),
      .rsp_class_score (rsp_class_score),
      .rsp_rank        (rsp_rank),
      .rsp_entry_valid (rsp_entry_valid),
      .rsp_last_result (rsp_last_result),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_top_count   (csr_top_count)
   );

   // 4 ns clock
   always #2 clock = ~clock;

   // ------------------------------------------------------------------
   // Side copy of the selector: sorted list, fill level, stream position
   // and the top_count register as last written.
   // ------------------------------------------------------------------
   logic signed [SCORE_W-1:0]  sel_scores  [K_MAX];
   logic [CLASS_IDX_W-1:0]     sel_indices [K_MAX];
   int                         sel_fill = 0;
   int                         sel_next = 0;
   logic [TOP_COUNT_W-1:0]     sel_top_count = TOP_COUNT_RESET;

   // ranked words still owed by the block, oldest first
   rsp_word_type               pending_ranks [$];
   int                         err_cnt = 0;
   int                         burst_left = 0;

   // Apply one accepted score word to the side list; on a last word, queue
   // the k ranked words it produces and start a fresh vector.
   task automatic select_top_k(input logic signed [SCORE_W-1:0] sc, input logic lst);
      int           k;
      int           pos;
      int           j;
      bit           hit;
      rsp_word_type w;
      // zero acts as one, anything above K_MAX saturates
      k = (sel_top_count == 0) ? 1 :
          ((int'(sel_top_count) > K_MAX) ? K_MAX : int'(sel_top_count));
      // a lowered k trims the tail for good
      if (sel_fill > k) sel_fill = k;
      // past MAX_ITEMS the score is dropped, but a last flag still reports
      if (sel_next < MAX_ITEMS) begin
         pos = sel_fill;
         hit = 1'b0;
         // strict compare: on a tie the earlier index stays ahead
         for (j = 0; j < sel_fill; j++) begin
            if (!hit && sc > sel_scores[j]) begin
               pos = j;
               hit = 1'b1;
            end
         end
         if (pos < k) begin
            if (sel_fill < k) sel_fill++;
            for (j = sel_fill - 1; j > pos; j--) begin
               sel_scores[j]  = sel_scores[j-1];
               sel_indices[j] = sel_indices[j-1];
            end
            sel_scores[pos]  = sc;
            sel_indices[pos] = CLASS_IDX_W'(sel_next);
         end
         sel_next++;
      end
      if (lst) begin
         for (j = 0; j < k; j++) begin
            // ranks never filled report zero index and score
            w.class_index = (j < sel_fill) ? sel_indices[j] : '0;
            w.class_score = (j < sel_fill) ? sel_scores[j] : '0;
            w.rank        = RANK_W'(j);
            w.entry_valid = (j < sel_fill);
            w.last_result = (j == k - 1);
            pending_ranks = {pending_ranks, w};
         end
         sel_fill = 0;
         sel_next = 0;
      end
   endtask

   // ------------------------------------------------------------------
   // Sender side. Data changes on the falling edge; a word is taken at the
   // rising edge where push is high and full is low. push stays high after
   // a word goes in, so the next call either follows on at once or lowers it.
   // ------------------------------------------------------------------
   task automatic send_word(input logic signed [SCORE_W-1:0] sc, input logic lst);
      @(negedge clock);
      push          <= 1'b1;
      req_score     <= sc;
      req_last_item <= lst;
      do @(posedge clock); while (full);
      select_top_k(sc, lst);
   endtask

   // bursts of random length separated by random idle gaps, zero gaps common
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 16);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
         if (gap > 0) begin
            @(negedge clock) push <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
   endtask

   // drop push, wait for every owed word, then let the pipe go quiet
   task automatic settle();
      @(negedge clock) push <= 1'b0;
      while (pending_ranks.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_top_count(input logic [TOP_COUNT_W-1:0] v);
      @(negedge clock);
      csr_valid     <= 1'b1;
      csr_top_count <= v;
      do @(posedge clock); while (!csr_ready);
      sel_top_count = v;
      @(negedge clock) csr_valid <= 1'b0;
   endtask

   function automatic logic signed [SCORE_W-1:0] draw_score(input int mode);
      case (mode)
         // tight range: lots of ties
         1: return SCORE_W'(int'($urandom_range(0, 8)) - 4);
         // corner values of the signed range
         2: begin
            case ($urandom_range(0, 4))
               0: return 32'sh8000_0000;
               1: return 32'sh7FFF_FFFF;
               2: return '0;
               3: return '1;
               default: return $urandom;
            endcase
         end
         // whole Q16.16 values around zero
         3: return {16'(int'($urandom_range(0, 200)) - 100), 16'h0000};
         default: return $urandom;
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Receiver side: pop changes on the falling edge, and a tick counter redraws
   // the mode of stalling so stalls land on every phase of the output.
   // ------------------------------------------------------------------
   int unsigned rx_tick = 0;
   int          rx_mode = 0;

   always @(negedge clock) begin
      rx_tick <= rx_tick + 1;
      if (rx_tick % 97 == 0) rx_mode <= $urandom_range(0, 3);
      case (rx_mode)
         0: pop <= 1'b1;
         1: pop <= $urandom_range(0, 1);
         2: pop <= ($urandom_range(0, 3) == 0);
         default: pop <= (rx_tick[2:0] != 3'd0);
      endcase
   end

   // ------------------------------------------------------------------
   // Result check on the rising edge: each popped word against the oldest
   // owed word.
   // ------------------------------------------------------------------
   function automatic void flag_field(input string fname, input logic [31:0] exp_v,
                                      input logic [31:0] act_v);
      $display("%0t ns: %s mismatch, expected %0h, actual %0h", $time, fname, exp_v, act_v);
      err_cnt++;
   endfunction

   rsp_word_type owed;

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (pending_ranks.size() == 0) begin
            $display("%0t ns: unexpected word, expected none, actual rank %0d index %0d score %0h",
                     $time, rsp_rank, rsp_class_index, rsp_class_score);
            err_cnt++;
         end else begin
            owed = pending_ranks.pop_front();
            if (rsp_class_index !== owed.class_index)
               flag_field("class_index", owed.class_index, rsp_class_index);
            if (rsp_class_score !== owed.class_score)
               flag_field("class_score", owed.class_score, rsp_class_score);
            if (rsp_rank !== owed.rank)
               flag_field("rank", owed.rank, rsp_rank);
            if (rsp_entry_valid !== owed.entry_valid)
               flag_field("entry_valid", owed.entry_valid, rsp_entry_valid);
            if (rsp_last_result !== owed.last_result)
               flag_field("last_result", owed.last_result, rsp_last_result);
         end
      end
   end

   // ------------------------------------------------------------------
   // Directed table. k_wr >= 0 writes top_count first (once idle). Rows with
   // typed set carry the rank-0 word by hand; the rest comes from the side
   // list.
   // ------------------------------------------------------------------
   typedef struct {
      int                        k_wr;
      logic signed [SCORE_W-1:0] sc;
      logic                      lst;
      bit                        typed;
      logic [CLASS_IDX_W-1:0]    t_ix;
      logic signed [SCORE_W-1:0] t_sc;
      logic                      t_vld;
   } dir_row_type;

   dir_row_type dir_tab [DIR_ROWS];

   // stimulus
   initial begin
      dir_row_type  row;
      rsp_word_type w;
      int           r;
      int           i;
      int           ph;
      int           n_rand;
      int           kk;
      int           eff;
      int           len;
      int           mode;
      int           mid;

      dir_tab = '{
         // reset k of 5, lone top score: one valid rank, four empty ones
         '{-1, 32'sh7FFF_FFFF, 1'b1, 1'b1, 10'd0, 32'sh7FFF_FFFF, 1'b1},
         // k of 1, most negative score still fills rank 0
         '{ 1, 32'sh8000_0000, 1'b1, 1'b1, 10'd0, 32'sh8000_0000, 1'b1},
         // zero top_count acts as 1: the larger later score wins
         '{ 0, 32'sh0000_000A, 1'b0, 1'b0, 10'd0, 32'sh0, 1'b0},
         '{-1, 32'sh0000_0014, 1'b1, 1'b1, 10'd1, 32'sh0000_0014, 1'b1},
         // all equal: earlier index ranks first
         '{ 3, 32'sh0001_0000, 1'b0, 1'b0, 10'd0, 32'sh0, 1'b0},
         '{-1, 32'sh0001_0000, 1'b0, 1'b0, 10'd0, 32'sh0, 1'b0},
         '{-1, 32'sh0001_0000, 1'b0, 1'b0, 10'd0, 32'sh0, 1'b0},
         '{-1, 32'sh0001_0000, 1'b1, 1'b0, 10'd0, 32'sh0, 1'b0},
         // 31 saturates to K_MAX; fewer scores than k, mixed corners
         '{31, 32'sh8000_0000, 1'b0, 1'b0, 10'd0, 32'sh0, 1'b0},
         '{-1, 32'sh7FFF_FFFF, 1'b0, 1'b0, 10'd0, 32'sh0, 1'b0},
         '{-1, 32'shFFFF_FFFF, 1'b0, 1'b0, 10'd0, 32'sh0, 1'b0},
         '{-1, 32'sh0000_0000, 1'b0, 1'b0, 10'd0, 32'sh0, 1'b0},
         '{-1, 32'shAAAA_AAAA, 1'b0, 1'b0, 10'd0, 32'sh0, 1'b0},
         '{-1, 32'sh5555_5555, 1'b1, 1'b1, 10'd1, 32'sh7FFF_FFFF, 1'b1},
         // k of 8, then cut to 2 mid-vector: tail is dropped
         '{ 8, 32'sh0009_0000, 1'b0, 1'b0, 10'd0, 32'sh0, 1'b0},
         '{-1, 32'sh0008_0000, 1'b0, 1'b0, 10'd0, 32'sh0, 1'b0},
         '{-1, 32'sh0007_0000, 1'b0, 1'b0, 10'd0, 32'sh0, 1'b0},
         '{-1, 32'sh0006_0000, 1'b0, 1'b0, 10'd0, 32'sh0, 1'b0},
         '{ 2, 32'sh0000_0001, 1'b1, 1'b1, 10'd0, 32'sh0009_0000, 1'b1},
         // back to 16: a fresh vector of one, -1.0
         '{16, 32'shFFFF_0000, 1'b1, 1'b1, 10'd0, 32'shFFFF_0000, 1'b1},
         // rising scores: later words move ahead
         '{-1, 32'sh0000_0001, 1'b0, 1'b0, 10'd0, 32'sh0, 1'b0},
         '{-1, 32'sh0000_0002, 1'b1, 1'b1, 10'd1, 32'sh0000_0002, 1'b1}
      };

      // synchronous reset, released on a falling edge
      repeat (7) @(posedge clock);
      @(negedge clock) reset <= 1'b0;

      // directed part, back to back, with sender gaps only before top_count writes
      for (r = 0; r < DIR_ROWS; r++) begin
         row = dir_tab[r];
         if (row.k_wr >= 0) begin
            settle();
            write_top_count(TOP_COUNT_W'(row.k_wr));
         end
         send_word(row.sc, row.lst);
         if (row.typed) begin
            // older words may pop meanwhile: find this vector's rank 0 from the end
            i = pending_ranks.size() - 1;
            while (pending_ranks[i].rank != '0) i--;
            w = pending_ranks[i];
            w.class_index = row.t_ix;
            w.class_score = row.t_sc;
            w.entry_valid = row.t_vld;
            pending_ranks[i] = w;
         end
      end

      // random part: phases of one k setting, each a few vectors
      ph = 0;
      n_rand = 0;
      while (n_rand < RAND_ITEMS) begin
         case (ph % 6)
            0: kk = 1;
            1: kk = K_MAX;
            2: kk = 0;
            3: kk = 31;
            default: kk = $urandom_range(0, 31);
         endcase
         settle();
         write_top_count(TOP_COUNT_W'(kk));
         eff = (kk == 0) ? 1 : ((kk > K_MAX) ? K_MAX : kk);

         repeat ($urandom_range(2, 6)) begin
            r = $urandom_range(0, 9);
            // mostly 1 to 2k+4 words, some 1 to k, some single words
            if (r < 6) len = $urandom_range(1, 2 * eff + 4);
            else if (r < 9) len = $urandom_range(1, eff);
            else len = 1;
            mode = $urandom_range(0, 3);
            // now and then change k in the middle of a vector
            mid = (len > 2 && $urandom_range(0, 7) == 0) ? len / 2 : -1;
            for (i = 0; i < len; i++) begin
               if (i == mid) begin
                  settle();
                  write_top_count(TOP_COUNT_W'($urandom_range(0, 31)));
               end
               pace();
               send_word(draw_score(mode), i == len - 1);
               n_rand++;
            end
         end
         ph++;
      end

      // drain, then give the pipe time to show any stray word
      settle();
      repeat (4 * SETTLE) @(posedge clock);
      if (err_cnt == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // hard stop, far beyond the slowest correct run
   initial begin
      #2_000_000;
      $display("Test completed with failures");
      $finish;
   end

endmodule
